### rtl/fsp_pkg.sv
`default_nettype none
package fsp_pkg;

  localparam int MAX_POINTS    = 65536;
  localparam int CORDIC_STAGES = 20;
  localparam int IDX_W         = 16;
  localparam int ANG_W         = 24;
  localparam int CNT_W         = 17;
  localparam int COORD_W       = 22;
  localparam int DIV_STEPS     = 24;
  localparam int SQRT_STEPS    = 20;
  localparam int MOD_STEPS     = 6;

  localparam int PREROT_ST     = MOD_STEPS;
  localparam int CORDIC_FIRST  = PREROT_ST + 1;
  localparam int CORDIC_LAST   = CORDIC_FIRST + CORDIC_STAGES - 1;
  localparam int MUL_ST        = CORDIC_LAST + 1;
  localparam int ABS_ST        = MUL_ST + 1;
  localparam int RND_ST        = ABS_ST + 1;
  localparam int SIGN_ST       = RND_ST + 1;
  localparam int BACK_STAGES   = SIGN_ST + 1;

  localparam logic [38:0]        TWO_PI_Q30  = 39'd6746518852;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [20:0]        COORD_MAX   = 21'd1048576;
  localparam logic [CNT_W-1:0]   MAX_CNT     = CNT_W'(MAX_POINTS);

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             err;
    logic             last;
    logic [ANG_W-1:0] theta;
  } item_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    v = '0;
    case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: begin
        if (i <= 30) v = 34'sd1 <<< (30 - i);
      end
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/fsp_front.sv
`default_nettype none
module fsp_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic [fsp_pkg::IDX_W-1:0] idx,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [23:0]               cfg_data,
  output logic                           push,
  output fsp_pkg::item_t                 push_item
);
  import fsp_pkg::*;

  typedef struct packed {
    logic        err;
    logic        last;
    logic [15:0] rem;
    logic [23:0] lo;
  } div_t;

  logic [ANG_W-1:0] start_r, end_r;
  logic [CNT_W-1:0] cnt_r;

  logic [CNT_W-1:0] n_sat;
  logic [15:0]      den;
  logic             single;
  logic [24:0]      dsub;
  logic             dneg;
  logic [23:0]      dabs;

  logic             v1_r, e1_r, l1_r;
  logic [15:0]      idx1_r;
  logic             v2_r, e2_r, l2_r;
  logic [39:0]      mag2_r;
  logic [40:0]      dvd_nxt;
  logic             dvv_r [DIV_STEPS+1];
  div_t             dv_r  [DIV_STEPS+1];
  logic             push_r;
  item_t            item_r;
  logic [23:0]      q_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= 24'd2058874;
      cnt_r   <= 17'd1000;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START: start_r <= cfg_data;
        CFG_END:   end_r   <= cfg_data;
        CFG_COUNT: cnt_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // the user must keep the config static while items are in flight; the block does not enforce this
  always_comb begin
    n_sat  = (cnt_r > MAX_CNT) ? MAX_CNT : cnt_r;
    den    = 16'(n_sat - 17'd1);
    single = (n_sat == 17'd1);
    dsub   = {1'b0, end_r} - {1'b0, start_r};
    dneg   = dsub[24];
    dabs   = dneg ? 24'(-dsub) : dsub[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= idx;
    e1_r   <= ({1'b0, idx} >= n_sat);
    l1_r   <= ({1'b0, idx} == 17'(n_sat - 17'd1));
    mag2_r <= 40'(idx1_r) * 40'(dabs);
    e2_r   <= e1_r;
    l2_r   <= l1_r;
  end

  assign dvd_nxt = {1'b0, mag2_r} + 41'(den >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) dvv_r[0] <= 1'b0;
    else        dvv_r[0] <= v2_r;
  end

  always_ff @(posedge clk) begin
    dv_r[0].err  <= e2_r;
    dv_r[0].last <= l2_r;
    dv_r[0].rem  <= dvd_nxt[39:24];
    dv_r[0].lo   <= dvd_nxt[23:0];
  end

  // one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [16:0] t;
    div_t        nx;
    always_comb begin
      t  = {dv_r[j].rem, dv_r[j].lo[23]};
      nx = dv_r[j];
      if (t >= {1'b0, den}) begin
        nx.rem = 16'(t - {1'b0, den});
        nx.lo  = {dv_r[j].lo[22:0], 1'b1};
      end else begin
        nx.rem = t[15:0];
        nx.lo  = {dv_r[j].lo[22:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dvv_r[j+1] <= 1'b0;
      else        dvv_r[j+1] <= dvv_r[j];
    end
    always_ff @(posedge clk) begin
      dv_r[j+1] <= nx;
    end
  end

  assign q_nxt = single ? '0 : dv_r[DIV_STEPS].lo;

  always_ff @(posedge clk) begin
    if (!rst_n) push_r <= 1'b0;
    else        push_r <= dvv_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    item_r.err   <= dv_r[DIV_STEPS].err;
    item_r.last  <= dv_r[DIV_STEPS].last;
    item_r.theta <= dneg ? start_r - q_nxt : start_r + q_nxt;
  end

  assign push      = push_r;
  assign push_item = item_r;

endmodule
`default_nettype wire

### rtl/fsp_queue.sv
`default_nettype none
module fsp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire fsp_pkg::item_t push_item,
  output logic                pop,
  output fsp_pkg::item_t      pop_item,
  output logic                full
);
  import fsp_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign pop      = (cnt_r != 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule
`default_nettype wire

### rtl/fsp_back.sv
`default_nettype none
module fsp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire fsp_pkg::item_t              in_item,
  output logic                             out_vld,
  output logic signed [fsp_pkg::COORD_W-1:0] out_x,
  output logic signed [fsp_pkg::COORD_W-1:0] out_y,
  output logic [fsp_pkg::ANG_W-1:0]        out_theta,
  output logic                             out_last,
  output logic                             out_err
);
  import fsp_pkg::*;

  typedef struct packed {
    logic                      err;
    logic                      last;
    logic [ANG_W-1:0]          theta;
    logic [41:0]               rem;
    logic [20:0]               root;
    logic [38:0]               ang;
    logic                      neg;
    logic signed [33:0]        x;
    logic signed [33:0]        y;
    logic signed [33:0]        z;
    logic signed [55:0]        px;
    logic signed [55:0]        py;
    logic [54:0]               mx;
    logic [54:0]               my;
    logic                      sx;
    logic                      sy;
    logic [20:0]               cx;
    logic [20:0]               cy;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
  } bk_t;

  bk_t  st   [BACK_STAGES+1];
  logic vld_r [BACK_STAGES+1];

  always_comb begin
    st[0]       = '0;
    st[0].err   = in_item.err;
    st[0].last  = in_item.last;
    st[0].theta = in_item.theta;
    st[0].rem   = {2'b0, in_item.theta, 16'b0};
    st[0].ang   = {1'b0, in_item.theta, 14'b0};
  end
  assign vld_r[0] = in_vld;

  for (genvar s = 0; s < BACK_STAGES; s++) begin : g_st
    localparam int K = (s < SQRT_STEPS) ? (SQRT_STEPS - 1 - s) : 0;
    localparam int J = (s < MOD_STEPS) ? (MOD_STEPS - 1 - s) : 0;
    localparam int I = (s >= CORDIC_FIRST && s <= CORDIC_LAST) ? (s - CORDIC_FIRST) : 0;
    bk_t                nx;
    logic [41:0]        trial;
    logic signed [33:0] a, dx, dy, c, sn;
    logic [54:0]        tx, ty;
    always_comb begin
      nx    = st[s];
      trial = '0;
      a     = '0;
      dx    = '0;
      dy    = '0;
      c     = '0;
      sn    = '0;
      tx    = '0;
      ty    = '0;
      if (s < MOD_STEPS) begin
        if (st[s].ang >= (TWO_PI_Q30 << J)) nx.ang = st[s].ang - (TWO_PI_Q30 << J);
      end
      if (s < SQRT_STEPS) begin
        trial = ({21'b0, st[s].root} << (K + 1)) | (42'd1 << (2 * K));
        if (st[s].rem >= trial) begin
          nx.rem  = st[s].rem - trial;
          nx.root = st[s].root | (21'd1 << K);
        end
      end
      if (s == SQRT_STEPS) begin
        if (st[s].rem > {21'b0, st[s].root}) nx.root = st[s].root + 21'd1;
      end
      if (s == PREROT_ST) begin
        a      = {1'b0, st[s].ang[32:0]};
        nx.neg = 1'b0;
        if (a > PI_Q30) a = a - $signed({1'b0, TWO_PI_Q30[32:0]});
        if (a > HALF_PI_Q30) begin
          a      = a - PI_Q30;
          nx.neg = 1'b1;
        end else if (a < -HALF_PI_Q30) begin
          a      = a + PI_Q30;
          nx.neg = 1'b1;
        end
        nx.z = a;
        nx.x = GAIN_Q30;
        nx.y = '0;
      end
      if (s >= CORDIC_FIRST && s <= CORDIC_LAST) begin
        dx = st[s].y >>> I;
        dy = st[s].x >>> I;
        if (!st[s].z[33]) begin
          nx.x = st[s].x - dx;
          nx.y = st[s].y + dy;
          nx.z = st[s].z - atan_q30(I);
        end else begin
          nx.x = st[s].x + dx;
          nx.y = st[s].y - dy;
          nx.z = st[s].z + atan_q30(I);
        end
      end
      if (s == MUL_ST) begin
        c     = st[s].neg ? -st[s].x : st[s].x;
        sn    = st[s].neg ? -st[s].y : st[s].y;
        nx.px = $signed({1'b0, st[s].root}) * c;
        nx.py = $signed({1'b0, st[s].root}) * sn;
      end
      if (s == ABS_ST) begin
        nx.sx = st[s].px[55];
        nx.sy = st[s].py[55];
        nx.mx = st[s].px[55] ? 55'(-st[s].px) : st[s].px[54:0];
        nx.my = st[s].py[55] ? 55'(-st[s].py) : st[s].py[54:0];
      end
      if (s == RND_ST) begin
        tx    = (st[s].mx + 55'(1 << 29)) >> 30;
        ty    = (st[s].my + 55'(1 << 29)) >> 30;
        nx.cx = (tx > 55'(COORD_MAX)) ? COORD_MAX : tx[20:0];
        nx.cy = (ty > 55'(COORD_MAX)) ? COORD_MAX : ty[20:0];
      end
      if (s == SIGN_ST) begin
        nx.ox = st[s].sx ? -$signed({1'b0, st[s].cx}) : $signed({1'b0, st[s].cx});
        nx.oy = st[s].sy ? -$signed({1'b0, st[s].cy}) : $signed({1'b0, st[s].cy});
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s+1] <= 1'b0;
      else        vld_r[s+1] <= vld_r[s];
    end
    always_ff @(posedge clk) begin
      st[s+1] <= nx;
    end
  end

  // out of range index reports zeros
  assign out_vld   = vld_r[BACK_STAGES];
  assign out_err   = st[BACK_STAGES].err;
  assign out_x     = st[BACK_STAGES].err ? '0 : st[BACK_STAGES].ox;
  assign out_y     = st[BACK_STAGES].err ? '0 : st[BACK_STAGES].oy;
  assign out_theta = st[BACK_STAGES].err ? '0 : st[BACK_STAGES].theta;
  assign out_last  = st[BACK_STAGES].err ? 1'b0 : st[BACK_STAGES].last;

endmodule
`default_nettype wire

### rtl/fermat_spiral_point_generator_core.sv
// throughput: one point per cycle, busy stays low in normal streaming
// front divider is 24 stages, back runs sqrt and a 20 stage cordic in parallel
// results are strobed for one cycle and cannot be stalled
// synchronous active-low reset clears all valid flags and loads register defaults
`default_nettype none
module fermat_spiral_point_generator_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [fsp_pkg::IDX_W-1:0]         in_point_index,
  output logic                                   out_valid,
  output logic signed [fsp_pkg::COORD_W-1:0]     out_x_coord,
  output logic signed [fsp_pkg::COORD_W-1:0]     out_y_coord,
  output logic [fsp_pkg::ANG_W-1:0]              out_angle_used,
  output logic                                   out_is_last,
  output logic                                   out_index_error,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [23:0]                       cfg_data
);
  import fsp_pkg::*;

  logic  acc, push, pop, full;
  item_t push_item, pop_item;

  assign busy = full;
  assign acc  = start && !full;

  fsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .idx       (in_point_index),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_item (push_item)
  );

  fsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full)
  );

  fsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (pop),
    .in_item   (pop_item),
    .out_vld   (out_valid),
    .out_x     (out_x_coord),
    .out_y     (out_y_coord),
    .out_theta (out_angle_used),
    .out_last  (out_is_last),
    .out_err   (out_index_error)
  );

endmodule
`default_nettype wire
